>>> hdl/longest_increasing_subsequence_top_macros.svh
// Assertion helpers for the top-level RTL file.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH

// Same-cycle implication.
`define LIS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in longest increasing subsequence block");

// Next-cycle implication.
`define LIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in longest increasing subsequence block");

`endif

>>> hdl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants and the sequencer state type of the subsequence block.
// ----------------------------------------------------------------------------
`default_nettype none

package lis_pkg;

  localparam int MAX_ELEMS_DEF = 64;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 6;
  localparam int LEN_W         = 7;
  localparam int OUT_TDATA_W   = 48;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DP_HEAD,
    ST_DP_VI,
    ST_DP_SCAN,
    ST_WALK_RD,
    ST_WALK_CHK
  } lis_state_t;

endpackage

`default_nettype wire

>>> hdl/longest_increasing_subsequence_top.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_top
// Finds a longest strictly increasing subsequence of a streamed run of values.
// ----------------------------------------------------------------------------
// Usage: values arrive on the in_ stream, one signed 32-bit value per beat;
// in_tlast marks the final beat of a run. Up to MAX_ELEMS values are kept;
// further beats are dropped and the overflow flag of the run is set.
// Loading accepts one beat per cycle. The last beat starts the computation and
// in_tready stays low until it completes. A single compare/add unit works
// through the quadratic length table, one (i, j) pair per cycle over the two
// store read ports. The walk back then reads the store from its end, one
// position per pass through the states ST_WALK_RD and ST_WALK_CHK.
// The out_ stream gives one beat per kept element, highest subsequence
// position first; out_tlast marks the beat with position 0. The result sits
// in an output register, so loading of the next run goes on while it waits.
// A stalled receiver halts the walk at the next kept element until the
// register frees. Reset (synchronous, active low) empties the store and
// clears the control flags but not the tdata, tuser and tlast registers;
// no clearing pass is needed since only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "longest_increasing_subsequence_top_macros.svh"

module longest_increasing_subsequence_top #(
  parameter int MAX_ELEMS = lis_pkg::MAX_ELEMS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: value[31:0]
  input  wire logic [lis_pkg::DATA_W-1:0]      in_tdata,
  input  wire logic                            in_tlast,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // out_tdata: element[31:0], position[37:32], seq_length[44:38], zero pad
  output logic [lis_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: overflow
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready
);

  localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMS + 1);
  localparam int DW    = lis_pkg::DATA_W;
  localparam int PAD_W = lis_pkg::OUT_TDATA_W - DW - lis_pkg::POS_W - lis_pkg::LEN_W;

  lis_pkg::lis_state_t state_r, state_nxt;

  logic [DW-1:0]    vmem [MAX_ELEMS];
  logic [CNT_W-1:0] lmem [MAX_ELEMS];

  logic [DW-1:0]    vrd_r;
  logic [CNT_W-1:0] lrd_r;
  logic [CNT_W-1:0] rd_idx;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             pend_r, pend_nxt;
  logic [DW-1:0]    vi_r, vi_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic [CNT_W-1:0] tgt_r, tgt_nxt;
  logic [DW-1:0]    bound_r, bound_nxt;
  logic             hb_r, hb_nxt;

  logic                       ov_r, ov_nxt;
  logic [DW-1:0]              o_elem_r, o_elem_nxt;
  logic [lis_pkg::POS_W-1:0]  o_pos_r, o_pos_nxt;
  logic [lis_pkg::LEN_W-1:0]  o_len_r, o_len_nxt;
  logic                       o_ovf_r, o_ovf_nxt;
  logic                       o_last_r, o_last_nxt;

  logic in_acc;
  logic issue;
  logic scan_done;
  logic row_last;
  logic walk_match;
  logic can_load;
  logic lwr_en;
  logic [CNT_W-1:0] best_upd;
  logic load_st;
  logic in_walk;
  logic last_emit;

  assign in_acc    = in_tvalid && in_tready;
  assign issue     = (j_r < i_r);
  assign scan_done = !issue && !pend_r;
  assign row_last  = ((i_r + 1'b1) == cnt_r);
  assign best_upd  = (len_r > best_r) ? len_r : best_r;
  assign can_load  = !ov_r || out_tready;
  assign walk_match = (lrd_r == tgt_r) &&
                      (!hb_r || ($signed(vrd_r) < $signed(bound_r)));
  assign lwr_en    = (state_r == lis_pkg::ST_DP_SCAN) && scan_done;
  assign load_st   = (state_r == lis_pkg::ST_LOAD);
  assign in_walk   = (state_r == lis_pkg::ST_WALK_RD) || (state_r == lis_pkg::ST_WALK_CHK);
  assign last_emit = (state_r == lis_pkg::ST_WALK_CHK) && walk_match && can_load &&
                     (tgt_r == CNT_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lis_pkg::ST_LOAD: begin
        if (in_acc && in_tlast) state_nxt = lis_pkg::ST_DP_HEAD;
      end
      lis_pkg::ST_DP_HEAD: state_nxt = lis_pkg::ST_DP_VI;
      lis_pkg::ST_DP_VI:   state_nxt = lis_pkg::ST_DP_SCAN;
      lis_pkg::ST_DP_SCAN: begin
        if (scan_done) begin
          state_nxt = row_last ? lis_pkg::ST_WALK_RD : lis_pkg::ST_DP_HEAD;
        end
      end
      lis_pkg::ST_WALK_RD: begin
        state_nxt = (w_r == '0) ? lis_pkg::ST_LOAD : lis_pkg::ST_WALK_CHK;
      end
      lis_pkg::ST_WALK_CHK: begin
        if (!walk_match) begin
          state_nxt = lis_pkg::ST_WALK_RD;
        end else if (can_load) begin
          state_nxt = (tgt_r == CNT_W'(1)) ? lis_pkg::ST_LOAD : lis_pkg::ST_WALK_RD;
        end
      end
      default: state_nxt = lis_pkg::ST_LOAD;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    in_tready  = (state_r == lis_pkg::ST_LOAD);
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    best_nxt   = best_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pend_nxt   = pend_r;
    vi_nxt     = vi_r;
    len_nxt    = len_r;
    w_nxt      = w_r;
    tgt_nxt    = tgt_r;
    bound_nxt  = bound_r;
    hb_nxt     = hb_r;
    ov_nxt     = ov_r && !out_tready;
    o_elem_nxt = o_elem_r;
    o_pos_nxt  = o_pos_r;
    o_len_nxt  = o_len_r;
    o_ovf_nxt  = o_ovf_r;
    o_last_nxt = o_last_r;
    rd_idx     = j_r;

    case (state_r)
      lis_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(MAX_ELEMS)) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt    = '0;
            best_nxt = '0;
          end
        end
      end
      lis_pkg::ST_DP_HEAD: begin
        rd_idx = i_r;
      end
      lis_pkg::ST_DP_VI: begin
        vi_nxt   = vrd_r;
        len_nxt  = CNT_W'(1);
        j_nxt    = '0;
        pend_nxt = 1'b0;
      end
      lis_pkg::ST_DP_SCAN: begin
        // Reads of position j issue here; the compare sees them in the following cycle.
        rd_idx   = j_r;
        pend_nxt = issue;
        if (issue) j_nxt = j_r + 1'b1;
        if (pend_r && ($signed(vi_r) > $signed(vrd_r)) &&
            ((lrd_r + 1'b1) > len_r)) begin
          len_nxt = lrd_r + 1'b1;
        end
        if (scan_done) begin
          best_nxt = best_upd;
          i_nxt    = i_r + 1'b1;
          if (row_last) begin
            w_nxt   = cnt_r;
            tgt_nxt = best_upd;
            hb_nxt  = 1'b0;
          end
        end
      end
      lis_pkg::ST_WALK_RD: begin
        rd_idx = w_r - 1'b1;
        if (w_r == '0) begin
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      lis_pkg::ST_WALK_CHK: begin
        rd_idx = w_r - 1'b1;
        if (!walk_match) begin
          w_nxt = w_r - 1'b1;
        end else if (can_load) begin
          ov_nxt     = 1'b1;
          o_elem_nxt = vrd_r;
          o_pos_nxt  = lis_pkg::POS_W'(tgt_r - 1'b1);
          o_len_nxt  = lis_pkg::LEN_W'(best_r);
          o_ovf_nxt  = ovf_r;
          o_last_nxt = (tgt_r == CNT_W'(1));
          bound_nxt  = vrd_r;
          hb_nxt     = 1'b1;
          tgt_nxt    = tgt_r - 1'b1;
          w_nxt      = w_r - 1'b1;
          if (tgt_r == CNT_W'(1)) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end
      end
      default: begin
        rd_idx = j_r;
      end
    endcase
  end

  // Stores: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (in_acc && (cnt_r < CNT_W'(MAX_ELEMS))) begin
      vmem[cnt_r[IDX_W-1:0]] <= in_tdata;
    end
    vrd_r <= vmem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lwr_en) begin
      lmem[i_r[IDX_W-1:0]] <= len_r;
    end
    lrd_r <= lmem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lis_pkg::ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      best_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      pend_r  <= 1'b0;
      w_r     <= '0;
      tgt_r   <= '0;
      hb_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      best_r  <= best_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      pend_r  <= pend_nxt;
      w_r     <= w_nxt;
      tgt_r   <= tgt_nxt;
      hb_r    <= hb_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vi_r     <= vi_nxt;
    len_r    <= len_nxt;
    bound_r  <= bound_nxt;
    o_elem_r <= o_elem_nxt;
    o_pos_r  <= o_pos_nxt;
    o_len_r  <= o_len_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{PAD_W{1'b0}}, o_len_r, o_pos_r, o_elem_r};
  assign out_tuser  = o_ovf_r;
  assign out_tlast  = o_last_r;

  `LIS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_ELEMS))
  `LIS_ASSERT_NOW(a_scan_order, state_r == lis_pkg::ST_DP_SCAN, j_r <= i_r)
  `LIS_ASSERT_NOW(a_walk_target, in_walk, tgt_r != '0)
  `LIS_ASSERT_NOW(a_last_pos0, ov_r && o_last_r, o_pos_r == '0)
  `LIS_ASSERT_NEXT(a_final_emit, last_emit, load_st && (cnt_r == '0) && out_tvalid && out_tlast)

endmodule

`default_nettype wire
